[design/cft_pkg.sv]
// shared types, constants and the arctangent table for the tilt filter
package cft_pkg;

    localparam int ANG_W      = 17;
    localparam int CFG_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int VEC_W      = 35;
    localparam int ZACC_W     = 26;
    localparam int TAB_IDX_W  = 5;

    localparam logic signed [ANG_W-1:0] ANG_LIMIT  = 17'sd46080;
    localparam logic signed [ZACC_W-1:0] Z_HALF_TURN = 26'sd11796480;

    localparam logic [CFG_W-1:0] WEIGHT_RESET = 16'd62415;
    localparam logic [CFG_W-1:0] GAIN_RESET   = 16'd51200;

    // register indexes of the configuration port
    localparam logic CFG_WEIGHT = 1'b0;
    localparam logic CFG_GAIN   = 1'b1;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_ROT,
        LN_MUL,
        LN_SUM,
        LN_DONE
    } t_lane_state;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ZACC_W-1:0] cft_atan(input logic [TAB_IDX_W-1:0] idx);
        logic signed [ZACC_W-1:0] v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/complementary_filter_tilt.sv]
// top level of the two-axis complementary tilt filter
//
// usage: one request on the input channel carries a raw imu sample (three
// accelerometer axes, x and y gyro rates). the block answers each request with
// one result request holding the new pitch and roll in 1/256 degree.
// input channel: i_valid / o_stall, output channel: o_valid / i_stall; a request
// moves at a clock edge with valid high and stall low.
// the pitch and roll lanes run side by side, each with its own cordic atan2
// stepping one rotation per clock; the merge register joins the two answers.
// an accepted request passes the cordic steps, the cordic finish and done
// registers, the lane states mul, sum and done, and the output register; o_stall
// stays high until both lanes have handed their result to the output register.
// a finished result sits in the output register while the next sample is
// already taken in; if i_stall holds that register, the lanes keep their new
// result and o_stall stays high until it can move forward.
// reset (synchronous, active low) clears both stored angles to zero and loads
// the default weight and gain; configuration writes belong to idle periods.
module complementary_filter_tilt #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [cft_pkg::CFG_W-1:0]           i_cfg_data,
    // sample request
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_accel_x,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_accel_y,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_accel_z,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_rate_x,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_rate_y,
    // angle request
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cft_pkg::ANG_W-1:0]    o_pitch_angle,
    output logic signed [cft_pkg::ANG_W-1:0]    o_roll_angle
);
    import cft_pkg::*;

    logic [CFG_W-1:0]        r_weight, r_gain;
    logic                    r_ovalid;
    logic signed [ANG_W-1:0] r_pitch, r_roll;

    t_lane_stat              w_pstat, w_rstat;
    logic signed [ANG_W-1:0] w_pang, w_rang;
    logic                    w_accept, w_take;

    // lanes only take a new sample when both are empty
    assign o_stall  = !(w_pstat.idle && w_rstat.idle);
    assign w_accept = i_valid && !o_stall;
    // move the finished pair into the output register when it is free
    assign w_take   = w_pstat.done && w_rstat.done && (!r_ovalid || !i_stall);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
            r_gain   <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WEIGHT: r_weight <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data;
                default:    r_weight <= r_weight;
            endcase
        end
    end

    // pitch: atan2(ay, az), gyro x adds
    cft_lane #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_acc_y  (i_accel_y),
        .i_acc_x  (i_accel_z),
        .i_rate   (i_rate_x),
        .i_sub    (1'b0),
        .i_weight (r_weight),
        .i_gain   (r_gain),
        .i_take   (w_take),
        .o_stat   (w_pstat),
        .o_angle  (w_pang)
    );

    // roll: atan2(ax, az), gyro y subtracts
    cft_lane #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_acc_y  (i_accel_x),
        .i_acc_x  (i_accel_z),
        .i_rate   (i_rate_y),
        .i_sub    (1'b1),
        .i_weight (r_weight),
        .i_gain   (r_gain),
        .i_take   (w_take),
        .o_stat   (w_rstat),
        .o_angle  (w_rang)
    );

    // merge stage: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pitch <= w_pang;
            r_roll  <= w_rang;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;

    // both lanes run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pstat == w_rstat)
        else $error("pitch and roll lanes out of step");

    // delivered angles stay within +-180 degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= ANG_LIMIT) && (o_pitch_angle >= -ANG_LIMIT)
                 && (o_roll_angle <= ANG_LIMIT) && (o_roll_angle >= -ANG_LIMIT))
        else $error("output angle out of range");

    // an accepted sample makes the lanes busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("lanes not busy after accepting a sample");

endmodule

[design/cft_cordic.sv]
// iterative vectoring cordic, one rotation step per clock, gives atan2 in 1/256 degree
module cft_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_y,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_x,
    output logic                                o_done,
    output logic signed [cft_pkg::ANG_W-1:0]    o_angle
);
    import cft_pkg::*;

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

    logic                     r_run, r_fin, r_done, r_zero;
    logic [IW-1:0]            r_i;
    logic signed [VEC_W-1:0]  r_x, r_y;
    logic signed [ZACC_W-1:0] r_z;
    logic signed [ANG_W-1:0]  r_angle;

    logic signed [VEC_W-1:0]  w_x0, w_y0, w_xs, w_ys;
    logic signed [ZACC_W-1:0] w_z0, w_tab, w_zr;
    logic signed [ANG_W-1:0]  n_angle;
    logic                     w_neg;

    // load: scale by 2^16, fold the left half-plane onto the right
    always_comb begin
        w_neg = i_x[SAMPLE_W-1];
        w_x0  = {{(VEC_W-SAMPLE_W-16){i_x[SAMPLE_W-1]}}, i_x, 16'b0};
        w_y0  = {{(VEC_W-SAMPLE_W-16){i_y[SAMPLE_W-1]}}, i_y, 16'b0};
        if (w_neg) begin
            w_x0 = -w_x0;
            w_y0 = -w_y0;
            w_z0 = i_y[SAMPLE_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
        end else begin
            w_z0 = '0;
        end
    end

    assign w_xs  = r_x >>> r_i;
    assign w_ys  = r_y >>> r_i;
    assign w_tab = cft_atan(TAB_IDX_W'(r_i));

    // round to 1/256 degree and clamp; an all-zero input vector gives zero
    always_comb begin
        w_zr = (r_z + 26'sd128) >>> 8;
        if (w_zr > ZACC_W'(ANG_LIMIT)) begin
            n_angle = ANG_LIMIT;
        end else if (w_zr < -ZACC_W'(ANG_LIMIT)) begin
            n_angle = -ANG_LIMIT;
        end else begin
            n_angle = w_zr[ANG_W-1:0];
        end
        if (r_zero) begin
            n_angle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_run && (r_i == LAST);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_i == LAST)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= w_x0;
            r_y    <= w_y0;
            r_z    <= w_z0;
            r_i    <= '0;
            r_zero <= (i_x == '0) && (i_y == '0);
        end else if (r_run) begin
            if (!r_y[VEC_W-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_tab;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_tab;
            end
            r_i <= r_i + 1'b1;
        end
        if (r_fin) begin
            r_angle <= n_angle;
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

[design/cft_lane.sv]
// one axis lane: gyro prediction, accelerometer angle, blend and the stored angle
module cft_lane #(
    parameter int STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_acc_y,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_acc_x,
    input  logic signed [cft_pkg::SAMPLE_W-1:0] i_rate,
    input  logic                                i_sub,
    input  logic [cft_pkg::CFG_W-1:0]           i_weight,
    input  logic [cft_pkg::CFG_W-1:0]           i_gain,
    input  logic                                i_take,
    output cft_pkg::t_lane_stat                 o_stat,
    output logic signed [cft_pkg::ANG_W-1:0]    o_angle
);
    import cft_pkg::*;

    t_lane_state r_state, n_state;

    logic signed [32:0]      r_gprod;
    logic signed [18:0]      r_gyro, n_gyro;
    logic signed [35:0]      r_pw;
    logic signed [34:0]      r_pa;
    logic signed [ANG_W-1:0] r_store, n_store;

    logic                    w_cdone;
    logic signed [ANG_W-1:0] w_acc;
    logic signed [33:0]      w_rnd;
    logic signed [17:0]      w_delta, w_comp;
    logic signed [36:0]      w_sum;
    logic signed [20:0]      w_sh;

    cft_cordic #(.STEPS(STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_y     (i_acc_y),
        .i_x     (i_acc_x),
        .o_done  (w_cdone),
        .o_angle (w_acc)
    );

    // gyro step, rounded to nearest
    always_comb begin
        w_rnd   = 34'(r_gprod) + 34'sd32768;
        w_delta = w_rnd[33:16];
        if (i_sub) begin
            n_gyro = 19'(r_store) - 19'(w_delta);
        end else begin
            n_gyro = 19'(r_store) + 19'(w_delta);
        end
    end

    // blend sum, floor shift and clamp
    always_comb begin
        w_comp = 18'sd65536 - $signed({2'b00, i_weight});
        w_sum  = 37'(r_pw) + 37'(r_pa);
        w_sh   = w_sum[36:16];
        if (w_sh > 21'(ANG_LIMIT)) begin
            n_store = ANG_LIMIT;
        end else if (w_sh < -21'(ANG_LIMIT)) begin
            n_store = -ANG_LIMIT;
        end else begin
            n_store = w_sh[ANG_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            LN_IDLE: if (i_start) n_state = LN_ROT;
            LN_ROT:  if (w_cdone) n_state = LN_MUL;
            LN_MUL:  n_state = LN_SUM;
            LN_SUM:  n_state = LN_DONE;
            LN_DONE: if (i_take) n_state = LN_IDLE;
            default: n_state = LN_IDLE;
        endcase
    end

    always_comb begin
        o_stat.idle = (r_state == LN_IDLE);
        o_stat.done = (r_state == LN_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
            r_store <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == LN_SUM) begin
                r_store <= n_store;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == LN_IDLE && i_start) begin
            r_gprod <= i_rate * $signed({1'b0, i_gain});
        end
        if (r_state == LN_ROT) begin
            r_gyro <= n_gyro;
        end
        if (r_state == LN_MUL) begin
            r_pw <= $signed({1'b0, i_weight}) * r_gyro;
            r_pa <= w_comp * w_acc;
        end
    end

    assign o_angle = r_store;

endmodule
